### design/frws_pkg.sv
// frws_pkg: shared widths, codes and reset values for frame rate window statistics
// used by the channel interfaces and by the top-level design module
package frws_pkg;

    // field widths
    localparam int unsigned RATE_W = 32;
    localparam int unsigned IVL_W  = 32;
    localparam int unsigned TPS_W  = 24;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned FRAC_W = 12;

    // rate numerator width: ticks_per_second scaled by 4096
    localparam int unsigned NUM_W  = TPS_W + FRAC_W;

    // reset value of ticks_per_second
    localparam logic [TPS_W-1:0] TPS_RESET = 24'd1000000;

    // request modes
    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_CLEAR  = 1'b1
    } t_mode;

endpackage

### design/frws_if.sv
// frws channel interfaces: frame request, result and ticks_per_second write
// depends on frws_pkg for field widths

// frame request channel
interface frws_frame_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [frws_pkg::IVL_W-1:0]    frame_interval;

    modport source (output valid, output mode, output frame_interval, input ready);
    modport sink   (input valid, input mode, input frame_interval, output ready);
endinterface

// result channel
interface frws_result_if;
    logic                              valid;
    logic                              ready;
    logic [frws_pkg::RATE_W-1:0]       current_rate;
    logic [frws_pkg::RATE_W-1:0]       average_rate;
    logic [frws_pkg::RATE_W-1:0]       minimum_rate;
    logic [frws_pkg::RATE_W-1:0]       maximum_rate;
    logic [frws_pkg::CNT_W-1:0]        sample_count;
    logic                              sample_ignored;

    modport source (output valid, output current_rate, output average_rate,
                    output minimum_rate, output maximum_rate, output sample_count,
                    output sample_ignored, input ready);
    modport sink   (input valid, input current_rate, input average_rate,
                    input minimum_rate, input maximum_rate, input sample_count,
                    input sample_ignored, output ready);
endinterface

// configuration write channel
interface frws_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [frws_pkg::TPS_W-1:0]       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/frws_div.sv
// frws_div: shared restoring divider, one quotient bit per cycle
// standalone, sized by parameters from the top level
module frws_div #(
    parameter int unsigned DW = 38,
    parameter int unsigned VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int unsigned SW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;
    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          q_bit;
    logic [VW-1:0] n_rem;

    // one trial subtract per cycle
    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_dvs};
        q_bit   = ~diff[VW];
        n_rem   = q_bit ? diff[VW-1:0] : shifted[VW-1:0];
    end

    // operand load and step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(DW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DW-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### design/frame_rate_window_statistics.sv
// frame_rate_window_statistics: top level, sequencer, history ring and statistics
// depends on frws_pkg, frws_if channel interfaces and the frws_div divider
//
//  channel   dir  handshake     carries
//  i_frame   in   valid/ready   mode, frame_interval
//  o_result  out  valid/ready   current_rate, average/minimum/maximum_rate,
//                               sample_count, sample_ignored
//  i_cfg     in   valid/ready   ticks_per_second (always ready)
//
// one request at a time, paced by the bit-serial divider (DW = 38 with a 60 entry window)
// used for the rate and then the average, and by the one-read-a-cycle ring scan
// a clear request skips the divider and the scan; a dropped sample skips the rate divide
// i_frame.ready is high only while idle; the result is held until taken
// synchronous active-low reset clears the ring pointers and sums, reloads ticks_per_second
module frame_rate_window_statistics #(
    parameter int unsigned WINDOW = 60
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    frws_frame_if.sink             i_frame,
    frws_result_if.source          o_result,
    frws_cfg_if.sink               i_cfg
);

    localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW    = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W = frws_pkg::RATE_W + CW;
    localparam int unsigned DW    = (SUM_W > frws_pkg::NUM_W) ? SUM_W : frws_pkg::NUM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RATE,
        ST_RD_OLD,
        ST_UPDATE,
        ST_SCAN,
        ST_DIV_AVG,
        ST_OUT
    } t_state;

    t_state                           r_state;
    logic [frws_pkg::TPS_W-1:0]       r_tps;
    logic [AW-1:0]                    r_pos;
    logic                             r_full;
    logic [frws_pkg::RATE_W-1:0]      r_latest;
    logic [SUM_W-1:0]                 r_sum;
    logic                             r_ign;
    logic [CW-1:0]                    r_idx;
    logic                             r_pend;
    logic                             r_first;
    logic [frws_pkg::RATE_W-1:0]      r_min;
    logic [frws_pkg::RATE_W-1:0]      r_max;
    logic                             r_out_vld;
    logic [frws_pkg::RATE_W-1:0]      r_out_cur;
    logic [frws_pkg::RATE_W-1:0]      r_out_avg;
    logic [frws_pkg::RATE_W-1:0]      r_out_min;
    logic [frws_pkg::RATE_W-1:0]      r_out_max;
    logic [CW-1:0]                    r_out_cnt;
    logic                             r_out_ign;

    // history ring memory
    logic [frws_pkg::RATE_W-1:0]      r_mem [WINDOW];
    logic [frws_pkg::RATE_W-1:0]      r_rd_data;
    logic [AW-1:0]                    rd_addr;

    logic                             accept;
    logic                             is_clear;
    logic                             is_bad;
    logic [CW-1:0]                    count;
    logic                             scan_end;
    logic                             div_start;
    logic [DW-1:0]                    div_dividend;
    logic [frws_pkg::RATE_W-1:0]      div_divisor;
    logic                             div_done;
    logic [DW-1:0]                    div_quo;
    logic [frws_pkg::RATE_W-1:0]      rate_sat;

    // request decode
    assign accept   = i_frame.valid & i_frame.ready;
    assign is_clear = (i_frame.mode == frws_pkg::MODE_CLEAR);
    assign is_bad   = (i_frame.frame_interval == '0) | i_frame.frame_interval[frws_pkg::IVL_W-1];

    assign count    = r_full ? CW'(WINDOW) : CW'(r_pos);
    assign scan_end = (r_state == ST_SCAN) && (r_idx >= count) && !r_pend && (count != '0);

    // divider operand selection: rate while idle, average at scan end
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DW'(r_sum);
        div_divisor  = frws_pkg::RATE_W'(count);
        if (r_state == ST_IDLE) begin
            div_start    = accept && !is_clear && !is_bad;
            div_dividend = DW'({r_tps, {frws_pkg::FRAC_W{1'b0}}});
            div_divisor  = i_frame.frame_interval;
        end else if (scan_end) begin
            div_start = 1'b1;
        end
    end

    // saturate the rate quotient to 32 bits
    assign rate_sat = (|div_quo[DW-1:frws_pkg::RATE_W]) ? '1 : div_quo[frws_pkg::RATE_W-1:0];

    frws_div #(
        .DW (DW),
        .VW (frws_pkg::RATE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // ring read address
    assign rd_addr = (r_state == ST_SCAN) ? r_idx[AW-1:0] : r_pos;

    // ring write and registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_mem[r_pos] <= r_latest;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tps     <= frws_pkg::TPS_RESET;
            r_pos     <= '0;
            r_full    <= 1'b0;
            r_latest  <= '0;
            r_sum     <= '0;
            r_ign     <= 1'b0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_first   <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            // configuration write
            if (i_cfg.valid) begin
                r_tps <= i_cfg.data;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_first <= 1'b1;
                    if (accept) begin
                        if (is_clear) begin
                            r_pos     <= '0;
                            r_full    <= 1'b0;
                            r_latest  <= '0;
                            r_sum     <= '0;
                            r_out_cur <= '0;
                            r_out_avg <= '0;
                            r_out_min <= '0;
                            r_out_max <= '0;
                            r_out_cnt <= '0;
                            r_out_ign <= 1'b0;
                            r_out_vld <= 1'b1;
                            r_state   <= ST_OUT;
                        end else if (is_bad) begin
                            r_ign   <= 1'b1;
                            r_state <= ST_SCAN;
                        end else begin
                            r_ign   <= 1'b0;
                            r_state <= ST_DIV_RATE;
                        end
                    end
                end
                ST_DIV_RATE: begin
                    if (div_done) begin
                        r_latest <= rate_sat;
                        r_state  <= ST_RD_OLD;
                    end
                end
                ST_RD_OLD: begin
                    r_state <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    // drop the overwritten entry once the ring is full
                    r_sum <= r_sum - (r_full ? SUM_W'(r_rd_data) : '0) + SUM_W'(r_latest);
                    if (r_pos == AW'(WINDOW - 1)) begin
                        r_pos  <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (count == '0) begin
                        r_out_cur <= r_latest;
                        r_out_avg <= '0;
                        r_out_min <= '0;
                        r_out_max <= '0;
                        r_out_cnt <= '0;
                        r_out_ign <= r_ign;
                        r_out_vld <= 1'b1;
                        r_state   <= ST_OUT;
                    end else begin
                        // issue one read a cycle
                        if (r_idx < count) begin
                            r_idx  <= r_idx + 1'b1;
                            r_pend <= 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                        end
                        // fold the returned entry into min and max
                        if (r_pend) begin
                            r_first <= 1'b0;
                            if (r_first || (r_rd_data < r_min)) begin
                                r_min <= r_rd_data;
                            end
                            if (r_first || (r_rd_data > r_max)) begin
                                r_max <= r_rd_data;
                            end
                        end
                        if (scan_end) begin
                            r_state <= ST_DIV_AVG;
                        end
                    end
                end
                ST_DIV_AVG: begin
                    if (div_done) begin
                        r_out_cur <= r_latest;
                        r_out_avg <= div_quo[frws_pkg::RATE_W-1:0];
                        r_out_min <= r_min;
                        r_out_max <= r_max;
                        r_out_cnt <= count;
                        r_out_ign <= r_ign;
                        r_out_vld <= 1'b1;
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (o_result.ready) begin
                        r_out_vld <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // channel drive
    assign i_frame.ready           = (r_state == ST_IDLE);
    assign i_cfg.ready             = 1'b1;
    assign o_result.valid          = r_out_vld;
    assign o_result.current_rate   = r_out_cur;
    assign o_result.average_rate   = r_out_avg;
    assign o_result.minimum_rate   = r_out_min;
    assign o_result.maximum_rate   = r_out_max;
    assign o_result.sample_count   = frws_pkg::CNT_W'(r_out_cnt);
    assign o_result.sample_ignored = r_out_ign;

endmodule

### tb/sv/frame_rate_window_statistics_tb.sv
// frame_rate_window_statistics_tb: self-checking bench for the frame rate window statistics block
// drives frame and ticks_per_second requests, predicts every result and compares it field by field
// depends on frws_pkg, the frws channel interfaces and the frame_rate_window_statistics design
module frame_rate_window_statistics_tb;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned WINDOW         = 60;
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned TIMEOUT_CYCLES = 1500000;

    typedef struct packed {
        logic [frws_pkg::RATE_W-1:0] current_rate;
        logic [frws_pkg::RATE_W-1:0] average_rate;
        logic [frws_pkg::RATE_W-1:0] minimum_rate;
        logic [frws_pkg::RATE_W-1:0] maximum_rate;
        logic [frws_pkg::CNT_W-1:0]  sample_count;
        logic                        sample_ignored;
    } t_window_stats;

    logic i_clk;
    logic i_rst_n;

    frws_frame_if  frame_ch ();
    frws_result_if result_ch ();
    frws_cfg_if    cfg_ch ();

    frame_rate_window_statistics #(
        .WINDOW (WINDOW)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // predicted copy of the block state
    logic [frws_pkg::TPS_W-1:0]  ticks_per_second;
    logic [frws_pkg::RATE_W-1:0] rate_ring [WINDOW];
    int unsigned                 ring_write_pos;
    logic                        ring_full;
    logic [frws_pkg::RATE_W-1:0] latest_rate;
    logic [37:0]                 ring_sum;

    // expected statistics in request order
    t_window_stats pending_stats [$];

    // idling controls and counters
    logic        sender_idles;
    logic        receiver_idles;
    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned dropped_samples;
    int unsigned clears_sent;
    int unsigned ring_wraps;
    int unsigned saturated_rates;
    int unsigned tps_writes;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout at %0t with %0d results outstanding", $time, pending_stats.size());
        $display("[frame_rate_window_statistics] ERROR");
        $finish;
    end

    // predict the statistics of one request and update the state copy
    function automatic t_window_stats predict_window_stats(frws_pkg::t_mode mode,
                                                           logic [frws_pkg::IVL_W-1:0] ivl);
        t_window_stats               stats;
        logic [frws_pkg::NUM_W-1:0]  quotient;
        logic [frws_pkg::RATE_W-1:0] rate;
        logic [frws_pkg::RATE_W-1:0] lo;
        logic [frws_pkg::RATE_W-1:0] hi;
        int unsigned                 count;
        stats = '0;
        if (mode == frws_pkg::MODE_CLEAR) begin
            ring_write_pos = 0;
            ring_full      = 1'b0;
            latest_rate    = '0;
            ring_sum       = '0;
            clears_sent++;
        end else if (ivl == '0 || ivl[frws_pkg::IVL_W-1]) begin
            stats.sample_ignored = 1'b1;
            dropped_samples++;
        end else begin
            quotient = {ticks_per_second, {frws_pkg::FRAC_W{1'b0}}}
                       / {{(frws_pkg::NUM_W-frws_pkg::IVL_W){1'b0}}, ivl};
            if (quotient > {{(frws_pkg::NUM_W-frws_pkg::RATE_W){1'b0}},
                            {frws_pkg::RATE_W{1'b1}}}) begin
                rate = '1;
                saturated_rates++;
            end else begin
                rate = quotient[frws_pkg::RATE_W-1:0];
            end
            latest_rate = rate;
            if (ring_full)
                ring_sum = ring_sum - rate_ring[ring_write_pos];
            rate_ring[ring_write_pos] = rate;
            ring_sum = ring_sum + rate;
            if (ring_write_pos == WINDOW - 1) begin
                ring_write_pos = 0;
                ring_full      = 1'b1;
                ring_wraps++;
            end else begin
                ring_write_pos++;
            end
        end
        count = ring_full ? WINDOW : ring_write_pos;
        stats.current_rate = latest_rate;
        stats.sample_count = count[frws_pkg::CNT_W-1:0];
        if (count > 0) begin
            lo = rate_ring[0];
            hi = rate_ring[0];
            for (int i = 1; i < count; i++) begin
                if (rate_ring[i] < lo) lo = rate_ring[i];
                if (rate_ring[i] > hi) hi = rate_ring[i];
            end
            stats.minimum_rate = lo;
            stats.maximum_rate = hi;
            stats.average_rate = frws_pkg::RATE_W'(ring_sum / count);
        end
        return stats;
    endfunction

    // compare one result field against its prediction
    function automatic void check_field(string field, logic [frws_pkg::RATE_W-1:0] want,
                                        logic [frws_pkg::RATE_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_results
        t_window_stats want;
        if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_stats.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual rate 0x%08h count %0d",
                         $time, result_ch.current_rate, result_ch.sample_count);
            end else begin
                want = pending_stats.pop_front();
                results_checked++;
                check_field("current_rate", want.current_rate, result_ch.current_rate);
                check_field("average_rate", want.average_rate, result_ch.average_rate);
                check_field("minimum_rate", want.minimum_rate, result_ch.minimum_rate);
                check_field("maximum_rate", want.maximum_rate, result_ch.maximum_rate);
                check_field("sample_count", frws_pkg::RATE_W'(want.sample_count),
                            frws_pkg::RATE_W'(result_ch.sample_count));
                check_field("sample_ignored", frws_pkg::RATE_W'(want.sample_ignored),
                            frws_pkg::RATE_W'(result_ch.sample_ignored));
            end
        end
    end

    // result backpressure in random bursts
    initial begin
        result_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (receiver_idles && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // send one frame request and record its predicted statistics
    task automatic send_frame_request(frws_pkg::t_mode mode, logic [frws_pkg::IVL_W-1:0] ivl);
        t_window_stats stats;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        frame_ch.valid          <= 1'b1;
        frame_ch.mode           <= mode;
        frame_ch.frame_interval <= ivl;
        do @(posedge i_clk); while (frame_ch.ready !== 1'b1);
        stats = predict_window_stats(mode, ivl);
        pending_stats.push_back(stats);
        requests_sent++;
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_until_drained();
        frame_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write ticks_per_second while the block is idle
    task automatic write_ticks_per_second(logic [frws_pkg::TPS_W-1:0] value);
        wait_until_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        ticks_per_second = value;
        tps_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    // interval mix: tiny, typical video, wide positive, and non-positive values
    function automatic logic [frws_pkg::IVL_W-1:0] random_interval();
        logic [frws_pkg::IVL_W-1:0] ivl;
        case ($urandom_range(0, 11))
            0:       ivl = $urandom_range(1, 64);
            1:       ivl = $urandom_range(65, 8000);
            2, 3, 4,
            5:       ivl = $urandom_range(8000, 200000);
            6, 7:    ivl = $urandom() & 32'h7FFF_FFFF;
            8:       ivl = $urandom() | 32'h8000_0000;
            9:       ivl = '0;
            default: ivl = $urandom();
        endcase
        return ivl;
    endfunction

    // random traffic with occasional history clears
    task automatic run_random_traffic(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 199) == 0)
                send_frame_request(frws_pkg::MODE_CLEAR, $urandom());
            else
                send_frame_request(frws_pkg::MODE_SAMPLE, random_interval());
        end
    endtask

    // reset rate, empty window, dropped samples and clears
    task automatic test_reset_rate_and_clears();
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h0000_0000);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h8000_0000);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h0000_0001);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h7FFF_FFFF);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'd16667);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h0000_0000);
        send_frame_request(frws_pkg::MODE_CLEAR, 32'h7FFF_FFFF);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h8000_0001);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'd33333);
        send_frame_request(frws_pkg::MODE_CLEAR, 32'h0000_0000);
        send_frame_request(frws_pkg::MODE_CLEAR, 32'hFFFF_FFFF);
    endtask

    // register extremes: saturation, zero rate, smallest rate
    task automatic test_tps_extremes();
        write_ticks_per_second(24'hFF_FFFF);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h0000_0001);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h0000_0002);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h7FFF_FFFF);
        write_ticks_per_second(24'h00_0000);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h0000_0001);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'd1000);
        write_ticks_per_second(24'h00_0001);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'h0000_0001);
        send_frame_request(frws_pkg::MODE_SAMPLE, 32'd4097);
        send_frame_request(frws_pkg::MODE_CLEAR, $urandom());
    endtask

    // random traffic under several rate settings with idling on both sides
    task automatic test_random_windows();
        write_ticks_per_second(frws_pkg::TPS_RESET);
        run_random_traffic(250);
        write_ticks_per_second(24'hFF_FFFF);
        run_random_traffic(250);
        write_ticks_per_second(24'd60);
        run_random_traffic(250);
        write_ticks_per_second(frws_pkg::TPS_W'($urandom_range(1, 24'hFF_FFFF)));
        run_random_traffic(250);
    endtask

    // back to back traffic with no idling
    task automatic test_steady_stream();
        write_ticks_per_second(frws_pkg::TPS_W'($urandom_range(1, 24'hFF_FFFF)));
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_random_traffic(220);
    endtask

    // main sequence
    initial begin
        i_rst_n                 = 1'b0;
        frame_ch.valid          = 1'b0;
        frame_ch.mode           = frws_pkg::MODE_SAMPLE;
        frame_ch.frame_interval = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.data             = '0;
        sender_idles            = 1'b1;
        receiver_idles          = 1'b1;
        error_count             = 0;
        requests_sent           = 0;
        results_checked         = 0;
        dropped_samples         = 0;
        clears_sent             = 0;
        ring_wraps              = 0;
        saturated_rates         = 0;
        tps_writes              = 0;
        ticks_per_second        = frws_pkg::TPS_RESET;
        ring_write_pos          = 0;
        ring_full               = 1'b0;
        latest_rate             = '0;
        ring_sum                = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rate_and_clears();
        test_tps_extremes();
        test_random_windows();
        test_steady_stream();

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results: %0d dropped samples, %0d clears",
                 requests_sent, results_checked, dropped_samples, clears_sent);
        $display("ring wrapped %0d times, %0d saturated rates, %0d rate register writes",
                 ring_wraps, saturated_rates, tps_writes);
        if (error_count == 0 && pending_stats.size() == 0) begin
            $display("[frame_rate_window_statistics] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count, pending_stats.size());
            $display("[frame_rate_window_statistics] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
design/frws_pkg.sv
design/frws_if.sv
design/frws_div.sv
design/frame_rate_window_statistics.sv
tb/sv/frame_rate_window_statistics_tb.sv
